// File: rtl/core/assert_macros.svh
// Assertion macros used by the arithmetic unit top.
// Depends on nothing; included by files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication check, sampled on clock, off during reset
`define ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// next-cycle implication check
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

// File: rtl/core/mfc_pkg.sv
// Shared types and codes of the arithmetic unit.
// Depends on nothing.
package mfc_pkg;
   localparam logic [3:0] ACT_ADD  = 4'd0;
   localparam logic [3:0] ACT_SUB  = 4'd1;
   localparam logic [3:0] ACT_MUL  = 4'd2;
   localparam logic [3:0] ACT_DIV  = 4'd3;
   localparam logic [3:0] ACT_REM  = 4'd4;
   localparam logic [3:0] ACT_POW  = 4'd5;
   localparam logic [3:0] ACT_FACT = 4'd6;
   localparam logic [3:0] ACT_SQR  = 4'd7;
   localparam logic [3:0] ACT_ROOT = 4'd8;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_DIV0    = 3'd1;
   localparam logic [2:0] ST_NEGROOT = 3'd2;
   localparam logic [2:0] ST_OVF     = 3'd3;
   localparam logic [2:0] ST_INVALID = 3'd4;

   // classified operation handed from front to back
   localparam logic [2:0] OP_DONE = 3'd0; // result settled in the front
   localparam logic [2:0] OP_MUL  = 3'd1;
   localparam logic [2:0] OP_DIV  = 3'd2;
   localparam logic [2:0] OP_REM  = 3'd3;
   localparam logic [2:0] OP_POW  = 3'd4;
   localparam logic [2:0] OP_FACT = 3'd5;
   localparam logic [2:0] OP_ROOT = 3'd6;

   typedef struct packed {
      logic [2:0]  op;
      logic        neg;     // sign of quotient/remainder or product
      logic [31:0] mag_a;   // magnitude or raw operand a
      logic [31:0] mag_b;   // magnitude or raw operand b
      logic [63:0] result;  // value for OP_DONE
      logic [2:0]  status;
   } task_type;
endpackage

// File: rtl/core/mfc_front.sv
// Front end: accepts items, classifies them and settles the quick ones.
// Depends on mfc_pkg.
module mfc_front #(
   parameter int FRACTION_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [3:0]        req_action,
   input  logic signed [31:0] req_operand_a,
   input  logic signed [31:0] req_operand_b,
   output logic              q_valid,
   input  logic              q_stall,
   output mfc_pkg::task_type q_task
);
   import mfc_pkg::*;

   localparam int DEPTH = 2;

   task_type   mem_ff [DEPTH];
   logic [0:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   task_type   t;
   logic       push, pop;
   logic signed [32:0] sum, dif;
   logic [31:0] ma, mb;

   assign req_stall = (cnt_ff == 2'(DEPTH));
   assign push = req_valid && !req_stall;
   assign q_valid = (cnt_ff != 2'd0);
   assign pop = q_valid && !q_stall;
   assign q_task = mem_ff[rd_ff];

   always_comb begin
      sum = 33'(req_operand_a) + 33'(req_operand_b);
      dif = 33'(req_operand_a) - 33'(req_operand_b);
      ma = req_operand_a[31] ? 32'(-req_operand_a) : req_operand_a;
      mb = req_operand_b[31] ? 32'(-req_operand_b) : req_operand_b;
      t.op = OP_DONE;
      t.neg = 1'b0;
      t.mag_a = ma;
      t.mag_b = mb;
      t.result = '0;
      t.status = ST_OK;
      unique case (req_action)
         ACT_ADD: t.result = 64'(64'(signed'(sum)) << FRACTION_BITS);
         ACT_SUB: t.result = 64'(64'(signed'(dif)) << FRACTION_BITS);
         ACT_MUL: begin
            t.op = OP_MUL;
            t.neg = req_operand_a[31] ^ req_operand_b[31];
         end
         ACT_SQR: t.op = OP_MUL;
         ACT_DIV: begin
            if (req_operand_b == 0) t.status = ST_DIV0;
            else begin
               t.op = OP_DIV;
               t.neg = req_operand_a[31] ^ req_operand_b[31];
            end
         end
         ACT_REM: begin
            if (req_operand_b == 0) t.status = ST_DIV0;
            else begin
               t.op = OP_REM;
               t.neg = req_operand_a[31];
            end
         end
         ACT_POW: begin
            t.mag_a = req_operand_a;
            t.mag_b = req_operand_b;
            if (req_operand_b[31] || req_operand_b == 0)
               t.result = 64'(64'd1 << FRACTION_BITS);
            else t.op = OP_POW;
         end
         ACT_FACT: begin
            t.mag_a = req_operand_a;
            if (req_operand_a[31] || req_operand_a < 2)
               t.result = 64'(64'd1 << FRACTION_BITS);
            else t.op = OP_FACT;
         end
         ACT_ROOT: begin
            if (req_operand_a[31]) t.status = ST_NEGROOT;
            else t.op = OP_ROOT;
         end
         default: t.status = ST_INVALID;
      endcase
      if (req_action == ACT_SQR) t.mag_b = ma;
   end

   always_comb begin
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= t;
   end
endmodule

// File: rtl/core/mfc_back.sv
// Back end: runs multiply, divide, remainder, power, factorial and root over cycles.
// Depends on mfc_pkg.
module mfc_back #(
   parameter int FRACTION_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_stall,
   input  mfc_pkg::task_type q_task,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [63:0]       rsp_result,
   output logic [2:0]        rsp_status
);
   import mfc_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RUN  = 2'd1;
   localparam logic [1:0] S_FIN  = 2'd2;
   localparam int DIV_STEPS  = 32 + FRACTION_BITS;
   localparam int ROOT_STEPS = 16 + FRACTION_BITS;
   localparam logic [63:0] LIM = 64'd1 << (63 - FRACTION_BITS);

   logic [1:0]  state_ff, state_in;
   logic [5:0]  cnt_ff, cnt_in;
   task_type    tk_ff, tk_in;
   logic [63:0] acc_ff, acc_in;   // quotient, root, product, power, factorial
   logic [64:0] rem_ff, rem_in;   // partial remainder
   logic [63:0] num_ff, num_in;   // shifting dividend / radicand / exponent
   logic [31:0] base_ff, base_in;
   logic        out_v_ff, out_v_in;
   logic [63:0] out_r_ff, out_r_in;
   logic [2:0]  out_s_ff, out_s_in;
   logic [64:0] trial;
   logic [63:0] prod, mag, fin;
   logic [31:0] fi;

   assign q_stall = (state_ff != S_IDLE) || (out_v_ff && rsp_stall);
   assign rsp_valid = out_v_ff;
   assign rsp_result = out_r_ff;
   assign rsp_status = out_s_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      tk_in = tk_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      num_in = num_ff;
      base_in = base_ff;
      out_v_in = out_v_ff && rsp_stall;
      out_r_in = out_r_ff;
      out_s_in = out_s_ff;
      trial = '0;
      prod = tk_ff.mag_a * tk_ff.mag_b;
      mag = '0;
      fin = '0;
      fi = 32'(cnt_ff);
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid && !q_stall) begin
               tk_in = q_task;
               acc_in = '0;
               rem_in = '0;
               cnt_in = '0;
               base_in = q_task.mag_a;
               if (q_task.op == OP_DIV)
                  num_in = 64'(q_task.mag_a) << FRACTION_BITS << (64 - DIV_STEPS);
               else if (q_task.op == OP_REM)
                  num_in = {q_task.mag_a, 32'd0};
               else if (q_task.op == OP_ROOT)
                  num_in = {q_task.mag_a, 32'd0};
               else num_in = 64'(q_task.mag_b);
               if (q_task.op == OP_POW || q_task.op == OP_FACT) acc_in = 64'd1;
               if (q_task.op == OP_FACT) cnt_in = 6'd2;
               if (q_task.op == OP_DONE) begin
                  out_v_in = 1'b1;
                  out_r_in = q_task.result;
                  out_s_in = q_task.status;
               end else state_in = S_RUN;
            end
         end
         S_RUN: begin
            unique case (tk_ff.op)
               OP_MUL: begin
                  acc_in = prod;
                  state_in = S_FIN;
               end
               OP_DIV, OP_REM: begin
                  // one restoring step per cycle
                  trial = {rem_ff[63:0], num_ff[63]} - 65'(tk_ff.mag_b);
                  num_in = num_ff << 1;
                  if (!trial[64]) begin
                     rem_in = trial;
                     acc_in = {acc_ff[62:0], 1'b1};
                  end else begin
                     rem_in = {rem_ff[63:0], num_ff[63]};
                     acc_in = {acc_ff[62:0], 1'b0};
                  end
                  cnt_in = cnt_ff + 6'd1;
                  if ((tk_ff.op == OP_DIV && cnt_ff == 6'(DIV_STEPS - 1)) ||
                      (tk_ff.op == OP_REM && cnt_ff == 6'd31))
                     state_in = S_FIN;
               end
               OP_ROOT: begin
                  trial = {rem_ff[62:0], num_ff[63:62]} - {acc_ff[62:0], 2'b01};
                  num_in = num_ff << 2;
                  if (!trial[64]) begin
                     rem_in = trial;
                     acc_in = {acc_ff[62:0], 1'b1};
                  end else begin
                     rem_in = {rem_ff[62:0], num_ff[63:62]};
                     acc_in = {acc_ff[62:0], 1'b0};
                  end
                  cnt_in = cnt_ff + 6'd1;
                  if (cnt_ff == 6'(ROOT_STEPS - 1)) state_in = S_FIN;
               end
               OP_POW: begin
                  // square-and-multiply, low exponent bit first
                  if (num_ff[0]) acc_in = 64'(acc_ff[31:0] * base_ff);
                  base_in = base_ff * base_ff;
                  num_in = num_ff >> 1;
                  if (num_ff[63:1] == '0) state_in = S_FIN;
               end
               OP_FACT: begin
                  acc_in = 64'(acc_ff[31:0] * fi);
                  cnt_in = cnt_ff + 6'd1;
                  if (fi >= tk_ff.mag_a || cnt_ff == 6'd34) state_in = S_FIN;
               end
               default: state_in = S_FIN;
            endcase
         end
         S_FIN: begin
            if (!out_v_ff || !rsp_stall) begin
               out_s_in = ST_OK;
               unique case (tk_ff.op)
                  OP_MUL: begin
                     if (acc_ff >= LIM + 64'(tk_ff.neg)) begin
                        out_s_in = ST_OVF;
                        fin = tk_ff.neg ? 64'h8000_0000_0000_0000
                                        : 64'h7fff_ffff_ffff_ffff;
                     end else begin
                        mag = acc_ff << FRACTION_BITS;
                        fin = tk_ff.neg ? 64'(-mag) : mag;
                     end
                  end
                  OP_DIV: fin = tk_ff.neg ? 64'(-acc_ff) : acc_ff;
                  OP_REM: begin
                     mag = rem_ff[63:0] << FRACTION_BITS;
                     fin = tk_ff.neg ? 64'(-mag) : mag;
                  end
                  OP_ROOT: fin = acc_ff;
                  default: fin = 64'(64'(signed'(acc_ff[31:0])) << FRACTION_BITS);
               endcase
               out_v_in = 1'b1;
               out_r_in = fin;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      tk_ff <= tk_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      num_ff <= num_in;
      base_ff <= base_in;
      out_r_ff <= out_r_in;
      out_s_ff <= out_s_in;
   end
endmodule

// File: rtl/core/multi_function_calculator_alu.sv
// Arithmetic unit: add, subtract, multiply, divide, remainder, power,
// factorial, square and square root on signed 32-bit operands, result in
// fixed point with FRACTION_BITS fraction bits. Add, subtract and rejected
// actions are settled in the front and pass through the queue and the back's
// output register; multiply and square form one product in the back; the
// iterative ones run their steps in the back: divide 32+FRACTION_BITS steps
// of the restoring divider, remainder 32, root 16+FRACTION_BITS, power one
// step per exponent bit, factorial one multiply per factor up to 34. A
// two-entry queue decouples the classifying front from the back.
// Depends on mfc_pkg, mfc_front, mfc_back and assert_macros.svh.
module multi_function_calculator_alu #(
   parameter int FRACTION_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [3:0]        req_action,
   input  logic signed [31:0] req_operand_a,
   input  logic signed [31:0] req_operand_b,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic signed [63:0] rsp_result,
   output logic [2:0]        rsp_status
);
   import mfc_pkg::*;
`include "assert_macros.svh"

   logic     q_valid, q_stall;
   task_type q_task;
   logic [63:0] res;

   mfc_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_action,
      .req_operand_a, .req_operand_b, .q_valid, .q_stall, .q_task
   );

   mfc_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
      .clock, .reset, .q_valid, .q_stall, .q_task,
      .rsp_valid, .rsp_stall, .rsp_result(res), .rsp_status
   );

   assign rsp_result = signed'(res);

   `ASSERT_IMPL(a_status_range, clock, reset, rsp_valid, rsp_status <= ST_INVALID)
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `ASSERT_IMPL(a_root_sign, clock, reset, rsp_valid && rsp_status == ST_NEGROOT,
      rsp_result == 0)
endmodule
